// ===== rtl/sti_pkg.sv =====
// Shared types and codes for the sorted table block.
`timescale 1ns / 1ps
package sti_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] entry_value;
    logic                     entry_valid;
    logic [COUNT_W-1:0]       entry_count;
    logic                     last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_HEAD,
    ST_DEL,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/sti_ram.sv =====
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module sti_ram #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [sti_pkg::WORD_W-1:0]    wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [sti_pkg::WORD_W-1:0]    rdata
);
  import sti_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sorted_table_insert_delete.sv =====
// Sorted table of signed words with insert, delete and in-order dump.
// Insert: walks down from the tail, shifting up each entry at or above the new value; empty or full skip the walk.
// Delete: one full forward pass that finds and closes the gap.
// Dump: per entry, a read of the store, then a load of the output register.
// All passes go through the single read port of the entry store; no new operation is taken until one ends.
// Reset clears the count and the sequencer; the store is not cleared and needs no sweep.
`timescale 1ns / 1ps
module sorted_table_insert_delete #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sti_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output sti_pkg::out_word_t out_word
);
  import sti_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     found_r, found_nxt;
  logic [1:0]               status_r, status_nxt;
  logic signed [WORD_W-1:0] value_r;
  logic                     out_valid_r;
  out_word_t                out_r, out_nxt;
  logic                     out_load;
  logic                     slot_free;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic signed [WORD_W-1:0] ram_wdata, ram_rdata;

  // shared compare unit
  logic ge_value, eq_value, at_tail;

  sti_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ge_value  = (ram_rdata >= value_r);
  assign eq_value  = (ram_rdata == value_r);
  assign at_tail   = ((CW'(idx_r) + CW'(1)) == count_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = value_r;
    ram_re     = 1'b0;
    ram_raddr  = idx_r;
    out_load   = 1'b0;
    out_nxt    = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = STAT_OK;
          found_nxt  = 1'b0;
          priority if (in_word.mode == MODE_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = STAT_FULL;
              state_nxt  = ST_RESP;
            end else if (count_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_word.value;
              count_nxt = count_r + CW'(1);
              state_nxt = ST_RESP;
            end else begin
              // walk down from the tail
              idx_nxt   = AW'(count_r - CW'(1));
              ram_re    = 1'b1;
              ram_raddr = AW'(count_r - CW'(1));
              state_nxt = ST_INS;
            end
          end else if (in_word.mode == MODE_DELETE) begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = ST_RESP;
            end else begin
              idx_nxt   = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = ST_DEL;
            end
          end else if (in_word.mode == MODE_DUMP) begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = ST_RESP;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_DUMP_RD;
            end
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_INS: begin
        ram_we = 1'b1;
        ram_waddr = idx_r + AW'(1);
        if (ge_value) begin
          // shift this entry up one place
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = ST_INS_HEAD;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_r - AW'(1);
          end
        end else begin
          ram_wdata = value_r;
          count_nxt = count_r + CW'(1);
          state_nxt = ST_RESP;
        end
      end
      ST_INS_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = value_r;
        count_nxt = count_r + CW'(1);
        state_nxt = ST_RESP;
      end
      ST_DEL: begin
        if (found_r) begin
          // close the gap
          ram_we    = 1'b1;
          ram_waddr = idx_r - AW'(1);
          ram_wdata = ram_rdata;
        end else if (eq_value) begin
          found_nxt = 1'b1;
        end
        if (at_tail) begin
          if (found_r || eq_value) begin
            count_nxt  = count_r - CW'(1);
            status_nxt = STAT_OK;
          end else begin
            status_nxt = STAT_NOTFOUND;
          end
          state_nxt = ST_RESP;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_r + AW'(1);
        end
      end
      ST_DUMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        if (slot_free) begin
          out_load            = 1'b1;
          out_nxt.status      = STAT_OK;
          out_nxt.entry_value = ram_rdata;
          out_nxt.entry_valid = 1'b1;
          out_nxt.entry_count = COUNT_W'(count_r);
          out_nxt.last        = at_tail;
          if (at_tail) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_DUMP_RD;
          end
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_load            = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.entry_value = '0;
          out_nxt.entry_valid = 1'b0;
          out_nxt.entry_count = COUNT_W'(count_r);
          out_nxt.last        = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (state_r == ST_IDLE && in_valid) begin
      value_r <= in_word.value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1) || count_r + CW'(1) == $past(count_r)))
    else $error("entry count moved by more than one");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !in_valid) |=> (count_r == $past(count_r)))
    else $error("entry count changed without an operation");

  a_ram_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("store read and write at the same address");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.entry_valid) |-> (out_r.status == STAT_OK))
    else $error("dumped entry with a non-ok status");

endmodule

// ===== tb/sorted_table_checker.sv =====
// Checker for the sorted table: mirrors the table, predicts result words, compares them.
`timescale 1ns / 1ps
module sorted_table_checker #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sti_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sti_pkg::out_word_t out_word,
  output int                 err_count,
  output int                 pending,
  output int                 table_count
);
  import sti_pkg::*;

  logic signed [WORD_W-1:0] shadow [DEPTH];
  int                       n_ent = 0;
  out_word_t                due_words [$];
  int                       mism = 0;
  out_word_t                want;

  function automatic out_word_t make_word(logic [1:0] st, logic signed [WORD_W-1:0] v,
                                          logic vld, logic lst);
    out_word_t r;
    r.status      = st;
    r.entry_value = v;
    r.entry_valid = vld;
    r.entry_count = n_ent[COUNT_W-1:0];
    r.last        = lst;
    return r;
  endfunction

  // Update the shadow table and queue every word the operation should emit.
  task automatic apply_op(in_word_t w);
    logic signed [WORD_W-1:0] v;
    int pos;
    int i;
    v = $signed(w.value);
    case (w.mode)
      MODE_INSERT: begin
        if (n_ent >= DEPTH) begin
          due_words.push_back(make_word(STAT_FULL, '0, 1'b0, 1'b1));
        end else begin
          pos = n_ent;
          for (i = 0; i < n_ent; i++) begin
            if (shadow[i] >= v) begin
              pos = i;
              break;
            end
          end
          for (i = n_ent; i > pos; i--) shadow[i] = shadow[i-1];
          shadow[pos] = v;
          n_ent++;
          due_words.push_back(make_word(STAT_OK, '0, 1'b0, 1'b1));
        end
      end
      MODE_DELETE: begin
        if (n_ent == 0) begin
          due_words.push_back(make_word(STAT_EMPTY, '0, 1'b0, 1'b1));
        end else begin
          pos = n_ent;
          for (i = 0; i < n_ent; i++) begin
            if (shadow[i] == v) begin
              pos = i;
              break;
            end
          end
          if (pos == n_ent) begin
            due_words.push_back(make_word(STAT_NOTFOUND, '0, 1'b0, 1'b1));
          end else begin
            for (i = pos; i + 1 < n_ent; i++) shadow[i] = shadow[i+1];
            n_ent--;
            due_words.push_back(make_word(STAT_OK, '0, 1'b0, 1'b1));
          end
        end
      end
      MODE_DUMP: begin
        if (n_ent == 0) begin
          due_words.push_back(make_word(STAT_EMPTY, '0, 1'b0, 1'b1));
        end else begin
          for (i = 0; i < n_ent; i++)
            due_words.push_back(make_word(STAT_OK, shadow[i], 1'b1, i + 1 == n_ent));
        end
      end
      default: begin
        // unused mode: table untouched, one plain word
        due_words.push_back(make_word(STAT_OK, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic flag(string what, out_word_t exp_w, out_word_t got);
    mism++;
    if (mism <= 10) begin
      $display("%0t: %s: expected st=%0d val=%0d vld=%0d cnt=%0d last=%0d",
               $realtime, what, exp_w.status, exp_w.entry_value, exp_w.entry_valid,
               exp_w.entry_count, exp_w.last);
      $display("    got st=%0d val=%0d vld=%0d cnt=%0d last=%0d",
               got.status, got.entry_value, got.entry_valid, got.entry_count, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_ent = 0;
      due_words.delete();
    end else begin
      // check the outgoing word first; a word taken at this edge cannot answer this input
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          flag("unexpected word", '0, out_word);
        end else begin
          want = due_words.pop_front();
          if (out_word.status !== want.status || out_word.entry_value !== want.entry_value ||
              out_word.entry_valid !== want.entry_valid ||
              out_word.entry_count !== want.entry_count || out_word.last !== want.last)
            flag("word mismatch", want, out_word);
        end
      end
      if (in_valid && !in_stall) apply_op(in_word);
    end
    err_count   <= mism;
    pending     <= due_words.size();
    table_count <= n_ent;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the sorted table testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
  import sti_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [WORD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int PHASE_ITEMS = 97;
  localparam int HOLD_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int err_count;
  int pending;
  int table_count;

  int unsigned idle_pct;
  int unsigned stall_pct;
  logic        pressure_on;

  logic signed [WORD_W-1:0] ins_log [$];

  sorted_table_insert_delete #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  sorted_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .err_count  (err_count),
    .pending    (pending),
    .table_count(table_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once pressure is requested.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && pressure_on) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it, and hold until taken.
  task automatic send(input logic [1:0] m, input logic signed [WORD_W-1:0] v);
    in_word_t w;
    w.mode  = m;
    w.value = v;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (m == MODE_INSERT) ins_log.push_back(v);
  endtask

  // Mix of duplicates-prone small values, extremes and full-range words.
  function automatic logic signed [WORD_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $signed($urandom_range(8)) - 4;
    if (r < 55) begin
      case ($urandom_range(6))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        3: return VAL_MAX - 1;
        4: return -1;
        5: return 1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_victim();
    int unsigned idx;
    logic signed [WORD_W-1:0] v;
    if (ins_log.size() == 0 || $urandom_range(3) == 0) return pick_value();
    idx = $urandom_range(ins_log.size() - 1);
    v = ins_log[idx];
    ins_log.delete(idx);
    return v;
  endfunction

  initial begin
    int  ph;
    int  k;
    int  r;
    bit  filling;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_word     <= '0;
    pressure_on <= 1'b0;
    stall_pct   <= 0;
    idle_pct    = 0;
    filling     = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-table cases, extremes, duplicates, absent value, drain to empty
    idle_pct = 29;
    stall_pct <= 29;
    send(MODE_DELETE, 5);
    send(MODE_DUMP, $urandom);
    send(MODE_UNUSED, $urandom);
    send(MODE_INSERT, VAL_MAX);
    send(MODE_INSERT, VAL_MIN);
    send(MODE_INSERT, 0);
    send(MODE_INSERT, -1);
    send(MODE_INSERT, 1);
    send(MODE_INSERT, 0);
    send(MODE_INSERT, VAL_MAX);
    send(MODE_INSERT, VAL_MIN);
    send(MODE_DUMP, 0);
    send(MODE_DELETE, 7);
    send(MODE_DELETE, 0);
    send(MODE_DELETE, VAL_MIN);
    send(MODE_DELETE, VAL_MAX);
    send(MODE_UNUSED, VAL_MIN);
    send(MODE_DUMP, VAL_MAX);
    send(MODE_DELETE, -1);
    send(MODE_DELETE, 1);
    send(MODE_DELETE, 0);
    send(MODE_DELETE, VAL_MIN);
    send(MODE_DELETE, VAL_MAX);
    send(MODE_DELETE, 0);
    send(MODE_DUMP, -1);
    ins_log.delete();

    // random: swing the table between empty and full under each idling pattern
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          pressure_on <= 1'b1;
        end
        1: begin
          idle_pct = 69;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 69;
        end
        default: begin
          idle_pct = 29;
          stall_pct <= 29;
        end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (filling && table_count >= DEPTH && $urandom_range(2) == 0) filling = 0;
        else if (!filling && table_count == 0 && $urandom_range(2) == 0) filling = 1;
        r = $urandom_range(99);
        if (r < 4) send(MODE_DUMP, $urandom);
        else if (r < 6) send(MODE_UNUSED, $urandom);
        else if (r < (filling ? 86 : 20)) send(MODE_INSERT, pick_value());
        else send(MODE_DELETE, pick_victim());
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
